### hdl/bta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

  localparam int REQ_W = 20;
  localparam int OFF_W = 16;
  localparam int NEED_W = REQ_W - 2;
  localparam int TGT_W = OFF_W - 3;
  localparam int WORD_SHIFT = 3;
  localparam int MIN_BLOCK_WORDS = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_NO_SPACE = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AWALK,
    S_ASETPREV,
    S_ASPLIT_HDR,
    S_ASPLIT_FTR,
    S_AHDR,
    S_FWALK,
    S_FNEXT,
    S_FPREVCHK,
    S_FPREV,
    S_FHDR,
    S_FFTR,
    S_FCLRPREV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hdl/bta_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bta_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [bta_pkg::REQ_W-1:0]   request_bytes;
  logic [bta_pkg::OFF_W-1:0]   payload_offset;

  modport source (output valid, command, request_bytes, payload_offset, input ready);
  modport sink (input valid, command, request_bytes, payload_offset, output ready);
endinterface

interface bta_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [bta_pkg::OFF_W-1:0]   granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink (input valid, status, granted_offset, output ready);
endinterface

`default_nettype wire

### hdl/bta_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/boundary_tag_first_fit_allocator.sv
// Allocate walks the heap block by block in first-fit order, then writes the tags (the next
// block's prev-used bit, or the split remainder's header and footer, then the granted header)
// and posts the result. Free walks block by block up to the target, merges it with a free next
// or previous block, writes the merged header and footer, clears the next block's prev-used
// bit and posts the result; a null or misaligned free posts its result without a walk.
// One item is in work at a time; the single tag memory sets the pace.
// After reset a clearing pass writes every tag word to rebuild the heap before items are taken.
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_first_fit_allocator #(
  parameter int HEAP_WORDS = 8192
) (
  input  wire logic clk,
  input  wire logic rst,
  bta_req_if.sink   req,
  bta_rsp_if.source rsp
);

  localparam int SW = $clog2(HEAP_WORDS + 1);
  localparam int AW = $clog2(HEAP_WORDS);
  localparam int TW = SW + 2;
  localparam int NXW = SW + 1;
  localparam int CW = ((SW > bta_pkg::NEED_W) ? SW : bta_pkg::NEED_W) + 2;
  localparam int GW = SW + 4;
  localparam int USED = SW;
  localparam int PREV = SW + 1;

  bta_pkg::state_t state, state_next;

  logic [AW-1:0]               clr, clr_next;
  logic [SW-1:0]               w, w_next;
  logic [SW-1:0]               blen, blen_next;
  logic [SW-1:0]               rest, rest_next;
  logic [NXW-1:0]              nx, nx_next;
  logic [bta_pkg::NEED_W-1:0]  need, need_next;
  logic [bta_pkg::TGT_W-1:0]   target, target_next;
  logic                        bprev, bprev_next;
  logic                        is_alloc, is_alloc_next;
  logic                        fail, fail_next;
  logic                        split, split_next;
  logic                        rsp_valid, rsp_valid_next;
  logic                        rsp_status, rsp_status_next;
  logic [bta_pkg::OFF_W-1:0]   rsp_offset, rsp_offset_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [TW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [TW-1:0] rdata;

  logic [SW-1:0]               rd_size;
  logic [CW-1:0]               wc, lenc, sum_wl, needc, diff, tgtc, hwc, blenc, sum_wb;
  logic [CW-1:0]               split_at, last_word;
  logic [bta_pkg::REQ_W:0]     req_round;
  logic [bta_pkg::NEED_W-1:0]  req_words;
  logic                        accept;

  bta_ram #(
    .WIDTH(TW),
    .DEPTH(HEAP_WORDS)
  ) u_tags (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  assign rd_size   = rdata[SW-1:0];
  assign wc        = CW'(w);
  assign lenc      = CW'(rd_size);
  assign sum_wl    = wc + lenc;
  assign needc     = CW'(need);
  assign diff      = lenc - needc;
  assign tgtc      = CW'(target);
  assign hwc       = CW'(HEAP_WORDS);
  assign blenc     = CW'(blen);
  assign sum_wb    = wc + blenc;
  assign split_at  = wc + needc;
  assign last_word = CW'(nx) - CW'(1);
  assign req_round = (bta_pkg::REQ_W + 1)'(req.request_bytes) + (bta_pkg::REQ_W + 1)'(7);
  assign req_words = req_round[bta_pkg::REQ_W:bta_pkg::WORD_SHIFT];
  assign accept    = req.valid && req.ready;

  assign req.ready          = (state == bta_pkg::S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.granted_offset = rsp_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bta_pkg::S_CLEAR;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    w          <= w_next;
    blen       <= blen_next;
    rest       <= rest_next;
    nx         <= nx_next;
    need       <= need_next;
    target     <= target_next;
    bprev      <= bprev_next;
    is_alloc   <= is_alloc_next;
    fail       <= fail_next;
    split      <= split_next;
    rsp_status <= rsp_status_next;
    rsp_offset <= rsp_offset_next;
  end

  always_comb begin
    state_next      = state;
    clr_next        = clr;
    w_next          = w;
    blen_next       = blen;
    rest_next       = rest;
    nx_next         = nx;
    need_next       = need;
    target_next     = target;
    bprev_next      = bprev;
    is_alloc_next   = is_alloc;
    fail_next       = fail;
    split_next      = split;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_offset_next = rsp_offset;
    mem_we          = 1'b0;
    mem_waddr       = AW'(w);
    mem_wdata       = '0;
    mem_raddr       = AW'(sum_wl);

    unique case (state)
      bta_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        if (clr == '0) begin
          mem_wdata = {1'b1, 1'b0, SW'(HEAP_WORDS)};
        end else if (clr == AW'(HEAP_WORDS - 1)) begin
          mem_wdata = {2'b00, SW'(HEAP_WORDS)};
        end
        if (clr == AW'(HEAP_WORDS - 1)) begin
          state_next = bta_pkg::S_IDLE;
        end else begin
          clr_next = clr + AW'(1);
        end
      end

      bta_pkg::S_IDLE: begin
        mem_raddr = '0;
        if (accept) begin
          w_next        = '0;
          fail_next     = 1'b0;
          is_alloc_next = (req.command == bta_pkg::CMD_ALLOC);
          need_next     = (req_words < bta_pkg::NEED_W'(bta_pkg::MIN_BLOCK_WORDS)) ?
                          bta_pkg::NEED_W'(bta_pkg::MIN_BLOCK_WORDS) :
                          req_words + bta_pkg::NEED_W'(1);
          target_next   = req.payload_offset[bta_pkg::OFF_W-1:bta_pkg::WORD_SHIFT] -
                          bta_pkg::TGT_W'(1);
          if (req.command == bta_pkg::CMD_ALLOC) begin
            state_next = bta_pkg::S_AWALK;
          end else if (req.payload_offset == '0 ||
                       req.payload_offset[bta_pkg::WORD_SHIFT-1:0] != '0) begin
            state_next = bta_pkg::S_DONE;
          end else begin
            state_next = bta_pkg::S_FWALK;
          end
        end
      end

      bta_pkg::S_AWALK: begin
        if (rd_size == '0) begin
          fail_next  = 1'b1;
          state_next = bta_pkg::S_DONE;
        end else if (!rdata[USED] && !diff[CW-1]) begin
          blen_next  = rd_size;
          bprev_next = rdata[PREV];
          nx_next    = NXW'(sum_wl);
          rest_next  = SW'(diff);
          if (diff < CW'(bta_pkg::MIN_BLOCK_WORDS)) begin
            split_next = 1'b0;
            state_next = (sum_wl < hwc) ? bta_pkg::S_ASETPREV : bta_pkg::S_AHDR;
          end else begin
            split_next = 1'b1;
            state_next = bta_pkg::S_ASPLIT_HDR;
          end
        end else begin
          w_next = SW'(sum_wl);
          if (sum_wl >= hwc) begin
            fail_next  = 1'b1;
            state_next = bta_pkg::S_DONE;
          end
        end
      end

      bta_pkg::S_ASETPREV: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(nx);
        mem_wdata  = {1'b1, rdata[TW-2:0]};
        state_next = bta_pkg::S_AHDR;
      end

      bta_pkg::S_ASPLIT_HDR: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(split_at);
        mem_wdata  = {1'b1, 1'b0, rest};
        state_next = bta_pkg::S_ASPLIT_FTR;
      end

      bta_pkg::S_ASPLIT_FTR: begin
        mem_we     = (last_word < hwc);
        mem_waddr  = AW'(last_word);
        mem_wdata  = {2'b00, rest};
        state_next = bta_pkg::S_AHDR;
      end

      bta_pkg::S_AHDR: begin
        mem_we     = 1'b1;
        mem_wdata  = {bprev, 1'b1, split ? SW'(need) : blen};
        state_next = bta_pkg::S_DONE;
      end

      bta_pkg::S_FWALK: begin
        if (wc < tgtc) begin
          if (rd_size == '0) begin
            state_next = bta_pkg::S_DONE;
          end else begin
            w_next = SW'(sum_wl);
            if (sum_wl >= hwc) begin
              state_next = bta_pkg::S_DONE;
            end
          end
        end else if (wc == tgtc && rdata[USED]) begin
          blen_next  = rd_size;
          bprev_next = rdata[PREV];
          state_next = (sum_wl < hwc) ? bta_pkg::S_FNEXT : bta_pkg::S_FPREVCHK;
        end else begin
          state_next = bta_pkg::S_DONE;
        end
      end

      bta_pkg::S_FNEXT: begin
        if (!rdata[USED]) begin
          blen_next = SW'(blenc + lenc);
        end
        state_next = bta_pkg::S_FPREVCHK;
      end

      bta_pkg::S_FPREVCHK: begin
        mem_raddr = AW'(wc - CW'(1));
        if (!bprev && w != '0) begin
          state_next = bta_pkg::S_FPREV;
        end else begin
          state_next = bta_pkg::S_FHDR;
        end
      end

      bta_pkg::S_FPREV: begin
        if (rd_size != '0 && lenc <= wc) begin
          blen_next = SW'(blenc + lenc);
          w_next    = SW'(wc - lenc);
        end
        state_next = bta_pkg::S_FHDR;
      end

      bta_pkg::S_FHDR: begin
        mem_we     = 1'b1;
        mem_wdata  = {1'b1, 1'b0, blen};
        state_next = bta_pkg::S_FFTR;
      end

      bta_pkg::S_FFTR: begin
        mem_we     = ((sum_wb - CW'(1)) < hwc);
        mem_waddr  = AW'(sum_wb - CW'(1));
        mem_wdata  = {2'b00, blen};
        mem_raddr  = AW'(sum_wb);
        nx_next    = NXW'(sum_wb);
        state_next = (sum_wb < hwc) ? bta_pkg::S_FCLRPREV : bta_pkg::S_DONE;
      end

      bta_pkg::S_FCLRPREV: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(nx);
        mem_wdata  = {1'b0, rdata[TW-2:0]};
        state_next = bta_pkg::S_DONE;
      end

      bta_pkg::S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = (is_alloc && fail) ? bta_pkg::ST_NO_SPACE : bta_pkg::ST_OK;
          rsp_offset_next = (is_alloc && !fail) ?
                            bta_pkg::OFF_W'((GW'(w) + GW'(1)) << bta_pkg::WORD_SHIFT) : '0;
          state_next      = bta_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bta_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/bta_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bta_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_ready,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic                      rsp_status,
  input wire logic [bta_pkg::OFF_W-1:0] rsp_granted_offset
);

  // Only one item is in work, so ready drops right after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after an item was accepted");

  // The clearing pass keeps the block closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("block open during the clearing pass");

  a_no_space_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == bta_pkg::ST_NO_SPACE |-> rsp_granted_offset == '0)
    else $error("failed allocation carries an offset");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_granted_offset[bta_pkg::WORD_SHIFT-1:0] == '0)
    else $error("granted offset is not word aligned");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_granted_offset))
    else $error("result changed while stalled");

endmodule

bind boundary_tag_first_fit_allocator bta_checker u_bta_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_granted_offset(rsp.granted_offset)
);

`default_nettype wire
